[src/prim_minimum_spanning_tree_assert.svh]
// Assertion macros used by the checker file of this block.
// Each macro checks on the rising clock edge and is held off while reset is low.
`ifndef PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH

// Same-cycle implication.
`define PMST_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("prim_mst check failed");

// Next-cycle implication.
`define PMST_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("prim_mst check failed");

`endif

[src/pmst_pkg.sv]
`default_nettype none

package pmst_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  // Fixed widths of the ports.
  localparam int VCNT_W     = 5;
  localparam int IN_DATA_W  = 16;
  localparam int VTX_OUT_W  = 4;
  localparam int WGT_OUT_W  = 16;
  localparam int OUT_DATA_W = 2 * VTX_OUT_W + WGT_OUT_W;

  // Vertex count after reset, limited by the configured maximum.
  localparam int VCNT_RESET = 16;

  typedef struct packed {
    logic clear;  // drop the running minimum before a new round
    logic cand;   // a crossing-edge candidate is on the read port
  } pmst_ctl_t;

endpackage

`default_nettype wire

[src/pmst_ram.sv]
`default_nettype none

module pmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/pmst_pick.sv]
`default_nettype none

module pmst_pick import pmst_pkg::*; #(
  parameter int VW = 4,
  parameter int WB = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pmst_ctl_t       ctl,
  input  wire logic [VW-1:0]   cand_i,
  input  wire logic [VW-1:0]   cand_j,
  input  wire logic [WB-1:0]   cand_w,
  output logic                 found,
  output logic [WB-1:0]        best,
  output logic [VW-1:0]        best_i,
  output logic [VW-1:0]        best_j
);

  logic          found_r;
  logic [WB-1:0] best_r;
  logic [VW-1:0] best_i_r;
  logic [VW-1:0] best_j_r;
  logic          take;

  // Only a strictly smaller weight replaces the minimum, so the first one seen wins ties.
  assign take = ctl.cand && (cand_w != '0) && (!found_r || (cand_w < best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_r   <= cand_w;
      best_i_r <= cand_i;
      best_j_r <= cand_j;
    end
  end

  assign found  = found_r;
  assign best   = best_r;
  assign best_i = best_i_r;
  assign best_j = best_j_r;

endmodule

`default_nettype wire

[src/prim_minimum_spanning_tree.sv]
// Load: one matrix word per cycle, n*n words for n active vertices.
// Compute: each of the n-1 rounds sweeps all n*n store entries through one
// compare unit, one per cycle, then holds its result word until it is taken.
// A new matrix is accepted in the cycle after the word with last set is taken.
// Reset clears the control state, sets the vertex count to 16 (at most MAX_VERTICES)
// and leaves the weight store as it was.
`default_nettype none

module prim_minimum_spanning_tree import pmst_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [VCNT_W-1:0]     cfg_wdata,   // vertex_count
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,    // weight
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,   // from_vertex, to_vertex, edge_weight
  output logic                       out_tuser,   // no_edge
  output logic                       out_tlast
);

  localparam int VW      = $clog2(MAX_VERTICES);
  localparam int NW      = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH   = MAX_VERTICES * MAX_VERTICES;
  localparam int AW      = $clog2(DEPTH);
  localparam int LCW     = $clog2(DEPTH + 1);
  localparam int N_RESET = (MAX_VERTICES < VCNT_RESET) ? MAX_VERTICES : VCNT_RESET;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic [LCW-1:0]          nn_r, nn_nxt;
  logic [LCW-1:0]          load_count_r, load_count_nxt;
  logic [MAX_VERTICES-1:0] in_tree_r, in_tree_nxt;
  logic [VW-1:0]           edges_r, edges_nxt;
  logic [VW-1:0]           i_r, i_nxt;
  logic [VW-1:0]           j_r, j_nxt;
  logic [AW-1:0]           base_r, base_nxt;
  logic                    p_valid_r, p_valid_nxt;
  logic [VW-1:0]           p_i_r, p_i_nxt;
  logic [VW-1:0]           p_j_r, p_j_nxt;

  logic                    in_acc;
  logic                    out_acc;
  logic                    row_end;
  logic                    last_row;
  logic                    load_done;
  logic                    last_edge;
  logic [NW-1:0]           cfg_n;
  logic [LCW-1:0]          cfg_nn;
  logic [AW-1:0]           rd_addr;
  logic [WEIGHT_BITS-1:0]  rd_data;
  pmst_ctl_t               pick_ctl;
  logic                    found;
  logic [WEIGHT_BITS-1:0]  best;
  logic [VW-1:0]           best_i;
  logic [VW-1:0]           best_j;

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_EMIT);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;

  assign row_end   = (NW'(j_r) == (n_r - NW'(1)));
  assign last_row  = (NW'(i_r) == (n_r - NW'(1)));
  assign load_done = ((load_count_r + LCW'(1)) == nn_r);
  assign last_edge = ((NW + 1)'(edges_r) + (NW + 1)'(2)) >= (NW + 1)'(n_r);
  assign rd_addr   = base_r + AW'(j_r);

  // A count of zero acts as one; counts above the maximum are clipped.
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_n = NW'(1);
    end else if (int'(cfg_wdata) > MAX_VERTICES) begin
      cfg_n = NW'(MAX_VERTICES);
    end else begin
      cfg_n = NW'(cfg_wdata);
    end
    cfg_nn = LCW'(cfg_n) * LCW'(cfg_n);
  end

  assign pick_ctl.cand  = p_valid_r;
  assign pick_ctl.clear = out_acc;

  pmst_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (load_count_r[AW-1:0]),
    .wdata (WEIGHT_BITS'(in_tdata)),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pmst_pick #(
    .VW (VW),
    .WB (WEIGHT_BITS)
  ) u_pick (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (pick_ctl),
    .cand_i (p_i_r),
    .cand_j (p_j_r),
    .cand_w (rd_data),
    .found  (found),
    .best   (best),
    .best_i (best_i),
    .best_j (best_j)
  );

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    nn_nxt         = nn_r;
    load_count_nxt = load_count_r;
    in_tree_nxt    = in_tree_r;
    edges_nxt      = edges_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    base_nxt       = base_r;
    p_valid_nxt    = 1'b0;
    p_i_nxt        = i_r;
    p_j_nxt        = j_r;

    case (state_r)
      S_LOAD: begin
        if (cfg_we) begin
          n_nxt          = cfg_n;
          nn_nxt         = cfg_nn;
          load_count_nxt = '0;
        end else if (in_acc) begin
          if (load_done) begin
            load_count_nxt = '0;
            // A single vertex has no edges, so the block just waits for the next matrix.
            if (n_r != NW'(1)) begin
              state_nxt = S_SCAN;
              i_nxt     = '0;
              j_nxt     = '0;
              base_nxt  = '0;
            end
          end else begin
            load_count_nxt = load_count_r + LCW'(1);
          end
        end
      end
      S_SCAN: begin
        // Entry (i, j) is a candidate when it crosses from the tree to a non-tree vertex.
        p_valid_nxt = in_tree_r[i_r] && !in_tree_r[j_r];
        if (row_end) begin
          j_nxt    = '0;
          i_nxt    = i_r + VW'(1);
          base_nxt = base_r + AW'(n_r);
          if (last_row) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          j_nxt = j_r + VW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          edges_nxt = edges_r + VW'(1);
          if (found) begin
            in_tree_nxt[best_j] = 1'b1;
          end
          if (last_edge) begin
            in_tree_nxt = MAX_VERTICES'(1);
            edges_nxt   = '0;
            state_nxt   = S_LOAD;
          end else begin
            state_nxt = S_SCAN;
            i_nxt     = '0;
            j_nxt     = '0;
            base_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      n_r          <= NW'(N_RESET);
      nn_r         <= LCW'(N_RESET * N_RESET);
      load_count_r <= '0;
      in_tree_r    <= MAX_VERTICES'(1);
      edges_r      <= '0;
      i_r          <= '0;
      j_r          <= '0;
      base_r       <= '0;
      p_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      n_r          <= n_nxt;
      nn_r         <= nn_nxt;
      load_count_r <= load_count_nxt;
      in_tree_r    <= in_tree_nxt;
      edges_r      <= edges_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      base_r       <= base_nxt;
      p_valid_r    <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_i_r <= p_i_nxt;
    p_j_r <= p_j_nxt;
  end

  assign out_tdata = found ? {WGT_OUT_W'(best), VTX_OUT_W'(best_j), VTX_OUT_W'(best_i)} : '0;
  assign out_tuser = !found;
  assign out_tlast = last_edge;

endmodule

`default_nettype wire

[src/pmst_chk.sv]
`default_nettype none
`include "prim_minimum_spanning_tree_assert.svh"

module pmst_chk import pmst_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  out_tlast
);

  // The block never loads while a result word is pending.
  `PMST_ASSERT_IMP(a_load_excl, in_tready, !out_tvalid)

  // A stalled result word keeps its contents.
  `PMST_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A round without a crossing edge reports zero vertices and zero weight.
  `PMST_ASSERT_IMP(a_no_edge_zero, out_tvalid && out_tuser, out_tdata == '0)

  // Once the final edge is taken, the next matrix can be loaded.
  `PMST_ASSERT_NXT(a_last_reload, out_tvalid && out_tready && out_tlast, in_tready)

endmodule

bind prim_minimum_spanning_tree pmst_chk u_pmst_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[verif/prim_minimum_spanning_tree_tb.sv]
`timescale 1ns / 1ps

module prim_minimum_spanning_tree_tb;
  import pmst_pkg::*;

  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [VTX_OUT_W-1:0] src;
    logic [VTX_OUT_W-1:0] dst;
    logic [WGT_OUT_W-1:0] wgt;
    logic                 cut;   // no crossing edge in this round
    logic                 fin;
  } mst_edge_t;

  typedef struct {
    logic [VCNT_W-1:0] vsel;
    int                nwords;
    logic              typed;
    mst_edge_t         want;
  } mst_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [VCNT_W-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  prim_minimum_spanning_tree DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Small rows with hand-worked results, a single vertex, the zero count, and a
  // partial load that is thrown away by a register write.
  mst_row_t dir_rows [6] = '{
    '{5'd2, 4, 1'b1, '{4'd0, 4'd1, 16'hFFFF, 1'b0, 1'b1}},
    '{5'd2, 4, 1'b1, '{4'd0, 4'd0, 16'h0000, 1'b1, 1'b1}},
    '{5'd1, 1, 1'b0, '{4'd0, 4'd0, 16'h0000, 1'b0, 1'b0}},
    '{5'd0, 1, 1'b0, '{4'd0, 4'd0, 16'h0000, 1'b0, 1'b0}},
    '{5'd3, 4, 1'b0, '{4'd0, 4'd0, 16'h0000, 1'b0, 1'b0}},
    '{5'd3, 9, 1'b0, '{4'd0, 4'd0, 16'h0000, 1'b0, 1'b0}}
  };
  logic [15:0] dir_words [23] = '{
    16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000,
    16'h8000, 16'h0000, 16'h7FFF, 16'h5555,
    16'hAAAA,
    16'h5555,
    16'h0001, 16'h0002, 16'h0003, 16'h0004,
    16'h0000, 16'h0005, 16'h0005,
    16'h0005, 16'h0000, 16'h0001,
    16'h0005, 16'h0001, 16'h0000
  };

  // Shadow of the block: matrix store, load position and vertex count.
  logic [15:0]       weights [MAX_VERTICES_DEF*MAX_VERTICES_DEF];
  int unsigned       loaded = 0;
  logic [VCNT_W-1:0] vcnt_shadow = VCNT_W'(VCNT_RESET);
  logic              hand_typed = 1'b0;
  mst_edge_t         tree_edges_q [$];

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int mismatches = 0;
  int matrices_run = 0;
  int edges_seen = 0;
  int cuts_seen = 0;
  int cfg_writes = 0;

  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_cnt = 0;

  function automatic int unsigned live_vertices(input logic [VCNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
    return int'(v);
  endfunction

  // Prim rounds from vertex 0; ties keep the first edge met in row, then column order.
  task automatic grow_tree(input int unsigned n);
    logic [MAX_VERTICES_DEF-1:0] joined;
    logic        found;
    logic [15:0] best;
    logic [15:0] w;
    int unsigned bx;
    int unsigned by;
    mst_edge_t   e;
    joined = MAX_VERTICES_DEF'(1);
    for (int r = 0; r + 1 < n; r++) begin
      found = 1'b0;
      best = '0;
      bx = 0;
      by = 0;
      for (int i = 0; i < n; i++) begin
        if (joined[i]) begin
          for (int j = 0; j < n; j++) begin
            w = weights[i*n + j];
            if (!joined[j] && w != 0 && (!found || w < best)) begin
              found = 1'b1;
              best = w;
              bx = i;
              by = j;
            end
          end
        end
      end
      if (found) joined[by] = 1'b1;
      e.src = bx[VTX_OUT_W-1:0];
      e.dst = by[VTX_OUT_W-1:0];
      e.wgt = best;
      e.cut = !found;
      e.fin = (r + 2 >= n);
      if (!hand_typed) tree_edges_q.push_back(e);
    end
    matrices_run++;
  endtask

  task automatic absorb_weight(input logic [15:0] w);
    int unsigned n;
    n = live_vertices(vcnt_shadow);
    if (loaded >= n*n) loaded = 0;
    weights[loaded] = w;
    loaded++;
    if (loaded == n*n) begin
      loaded = 0;
      grow_tree(n);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      vcnt_shadow = cfg_wdata;
      loaded = 0;
    end
    if (rst_n && in_tvalid && in_tready) absorb_weight(in_tdata);
  end

  // Receiver: random back-pressure, or a long hold-off when the sender asks for one.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_cnt <= 2000;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic report_edge(input string what, input mst_edge_t want, input mst_edge_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %0d->%0d w=%0d no_edge=%0b last=%0b, got %0d->%0d w=%0d no_edge=%0b last=%0b",
               what, want.src, want.dst, want.wgt, want.cut, want.fin,
               got.src, got.dst, got.wgt, got.cut, got.fin);
  endtask

  always @(posedge clk) begin : edge_check
    mst_edge_t got;
    mst_edge_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.src = out_tdata[VTX_OUT_W-1:0];
      got.dst = out_tdata[2*VTX_OUT_W-1:VTX_OUT_W];
      got.wgt = out_tdata[OUT_DATA_W-1:2*VTX_OUT_W];
      got.cut = out_tuser;
      got.fin = out_tlast;
      edges_seen++;
      if (got.cut) cuts_seen++;
      if (tree_edges_q.size() == 0) begin
        report_edge("unexpected word", '0, got);
      end else begin
        want = tree_edges_q.pop_front();
        if (got.src != want.src || got.dst != want.dst || got.wgt != want.wgt ||
            got.cut != want.cut || got.fin != want.fin)
          report_edge("edge mismatch", want, got);
      end
    end
  end

  task automatic send_word(input logic [15:0] w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // The register is only written once all results are out and the block has settled.
  task automatic set_vertices(input logic [VCNT_W-1:0] v);
    in_tvalid <= 1'b0;
    // Waiting on the clock lets the predictor queue the results of the word just taken.
    @(posedge clk);
    while (tree_edges_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  // 0: small weights with many ties, 1: full range, 2: mostly absent edges, 3: extremes.
  function automatic logic [15:0] pick_weight(input int mode);
    case (mode)
      0: begin
        if ($urandom_range(9) < 3) return 16'h0000;
        return 16'($urandom_range(4, 1));
      end
      1: begin
        if ($urandom_range(9) == 0) return 16'h0000;
        return 16'($urandom_range(16'hFFFF));
      end
      2: begin
        if ($urandom_range(3) != 0) return 16'h0000;
        return 16'($urandom_range(255, 1));
      end
      default: begin
        case ($urandom_range(3))
          0: return 16'h0001;
          1: return 16'hFFFF;
          2: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_matrix(input int unsigned words, input int mode);
    for (int k = 0; k < words; k++) send_word(pick_weight(mode));
  endtask

  task automatic random_phase(input int budget);
    int          sent;
    int          pick;
    int          reps;
    int unsigned n;
    int unsigned part;
    logic [VCNT_W-1:0] v;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 6) v = VCNT_W'($urandom_range(1));
      else if (pick < 76) v = VCNT_W'($urandom_range(5, 2));
      else v = VCNT_W'($urandom_range(9, 6));
      set_vertices(v);
      n = live_vertices(v);
      reps = $urandom_range(3, 1);
      for (int m = 0; m < reps && sent < budget; m++) begin
        send_matrix(n*n, $urandom_range(3));
        sent += n*n;
      end
      // Now and then leave a matrix partly loaded; the next register write drops it.
      if (n > 1 && $urandom_range(9) == 0) begin
        part = $urandom_range(n*n - 1, 1);
        send_matrix(part, 1);
        sent += part;
      end
    end
  endtask

  initial begin
    int wi;
    wi = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 6;
    out_idle_pct = 82;
    for (int r = 0; r < 6; r++) begin
      set_vertices(dir_rows[r].vsel);
      hand_typed = dir_rows[r].typed;
      if (dir_rows[r].typed) tree_edges_q.push_back(dir_rows[r].want);
      for (int k = 0; k < dir_rows[r].nwords; k++) begin
        send_word(dir_words[wi]);
        wi++;
      end
    end
    set_vertices(5'd2);
    hand_typed = 1'b0;
    random_phase(35);

    in_idle_pct = 82;
    out_idle_pct = 6;
    random_phase(35);

    in_idle_pct = 0;
    out_idle_pct = 0;
    // Results are held back while further matrices keep coming, so the input stalls.
    set_vertices(5'd4);
    hold_go <= ~hold_go;
    for (int m = 0; m < 3; m++) send_matrix(16, 1);
    set_vertices(5'd31);
    send_matrix(256, 1);
    random_phase(35);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tree_edges_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("Ran %0d matrices over %0d register writes, vertex counts 0 to 31.",
             matrices_run, cfg_writes);
    $display("Checked %0d tree edges, %0d of them rounds with no crossing edge.",
             edges_seen, cuts_seen);
    if (mismatches == 0 && tree_edges_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d edges still awaited.", tree_edges_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/pmst_pkg.sv
src/pmst_ram.sv
src/pmst_pick.sv
src/prim_minimum_spanning_tree.sv
src/pmst_chk.sv
verif/prim_minimum_spanning_tree_tb.sv
